// ===== rtl/core/fcce_pkg.sv =====
// Package of shared types and constants for the FAT16 cluster chain engine.
`default_nettype none

package fcce_pkg;

	localparam int unsigned CFG_W = 13;
	localparam int unsigned CNT_W = 17;

	localparam logic [15:0] LINK_FREE      = 16'h0000;
	localparam logic [15:0] LINK_EOC       = 16'hFFFF;
	localparam logic [15:0] LINK_MEDIA     = 16'hFFF8;
	localparam logic [15:0] LINK_LAST_DATA = 16'hFFF7;
	localparam logic [15:0] FIRST_DATA     = 16'h0002;
	localparam logic [CFG_W-1:0] ACTIVE_RESET = 13'd4096;

	typedef enum logic [1:0] {
		KIND_WRITE = 2'd0,
		KIND_READ  = 2'd1,
		KIND_ALLOC = 2'd2,
		KIND_FREE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_LIMIT = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		VAL_ZERO  = 2'd0,
		VAL_RDATA = 2'd1,
		VAL_FOUND = 2'd2
	} val_sel_t;

	typedef struct packed {
		kind_t       kind;
		logic [15:0] cluster_index;
		logic [15:0] entry_value;
		logic [15:0] link_from;
	} fcce_item_t;

	typedef struct packed {
		logic [15:0]      result_value;
		logic [CFG_W-1:0] freed_count;
		status_t          status;
	} fcce_result_t;

	typedef struct packed {
		logic     load;
		logic     clr_wr;
		logic     wr_idx;
		logic     rd_idx;
		logic     scan_start;
		logic     scan_step;
		logic     mark;
		logic     link;
		logic     walk_rd;
		logic     walk_clr;
		logic     fin;
		status_t  fin_status;
		val_sel_t fin_val;
	} fcce_ctrl_t;

	typedef struct packed {
		kind_t kind;
		logic  clr_last;
		logic  idx_ok;
		logic  prev_bad;
		logic  prev_nz;
		logic  found;
		logic  scan_more;
		logic  cur_data;
		logic  cur_ok;
		logic  limit;
	} fcce_stat_t;

endpackage

`default_nettype wire

// ===== rtl/core/fcce_datapath.sv =====
// Datapath of the FAT16 cluster chain engine: table memory, pointers and result register.
`default_nettype none

module fcce_datapath #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  fcce_pkg::fcce_item_t         item,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [fcce_pkg::CFG_W-1:0]    cfg_data,
	input  fcce_pkg::fcce_ctrl_t         ctrl,
	output fcce_pkg::fcce_stat_t         stat,
	output fcce_pkg::fcce_result_t       result
);
	import fcce_pkg::*;

	localparam int unsigned AW = $clog2(TABLE_DEPTH);
	localparam int unsigned CW = $clog2(TABLE_DEPTH + 1);

	logic [15:0]      mem [TABLE_DEPTH];
	logic [15:0]      rdata_q;
	logic [CFG_W-1:0] active_q;
	kind_t            kind_q;
	logic [15:0]      idx_q;
	logic [15:0]      val_q;
	logic [15:0]      prev_q;
	logic [15:0]      cur_q;
	logic [CFG_W-1:0] freed_q;
	logic [CW-1:0]    ptr_q;
	logic [AW-1:0]    rd_addr_q;
	logic             rd_valid_q;
	fcce_result_t     result_q;

	logic [CNT_W-1:0] active_ext;
	logic [CNT_W-1:0] depth_ext;
	logic [CNT_W-1:0] count;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [15:0]      wr_data;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [15:0]      clr_data;
	logic [15:0]      res_val;

	assign cfg_ready  = 1'b1;
	assign active_ext = CNT_W'(active_q);
	assign depth_ext  = CNT_W'(TABLE_DEPTH);
	assign count      = (active_ext < depth_ext) ? active_ext : depth_ext;

	always_comb begin
		if (ptr_q == CW'(0)) begin
			clr_data = LINK_MEDIA;
		end else if (ptr_q == CW'(1)) begin
			clr_data = LINK_EOC;
		end else begin
			clr_data = LINK_FREE;
		end
	end

	always_comb begin
		wr_en   = ctrl.clr_wr | ctrl.wr_idx | ctrl.mark | ctrl.link | ctrl.walk_clr;
		wr_addr = ptr_q[AW-1:0];
		wr_data = clr_data;
		if (ctrl.wr_idx) begin
			wr_addr = idx_q[AW-1:0];
			wr_data = val_q;
		end else if (ctrl.mark) begin
			wr_addr = rd_addr_q;
			wr_data = LINK_EOC;
		end else if (ctrl.link) begin
			wr_addr = prev_q[AW-1:0];
			wr_data = 16'(rd_addr_q);
		end else if (ctrl.walk_clr) begin
			wr_addr = cur_q[AW-1:0];
			wr_data = LINK_FREE;
		end
	end

	always_comb begin
		rd_en   = ctrl.rd_idx | ctrl.scan_step | ctrl.walk_rd;
		rd_addr = ptr_q[AW-1:0];
		if (ctrl.rd_idx) begin
			rd_addr = idx_q[AW-1:0];
		end else if (ctrl.walk_rd) begin
			rd_addr = cur_q[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rdata_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= ACTIVE_RESET;
			ptr_q      <= '0;
			rd_valid_q <= 1'b0;
			freed_q    <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				active_q <= cfg_data;
			end
			if (ctrl.load) begin
				freed_q <= '0;
			end else if (ctrl.walk_clr) begin
				freed_q <= freed_q + CFG_W'(1);
			end
			if (ctrl.scan_start) begin
				ptr_q      <= CW'(FIRST_DATA);
				rd_valid_q <= 1'b0;
			end else if (ctrl.scan_step) begin
				ptr_q      <= ptr_q + CW'(1);
				rd_valid_q <= 1'b1;
			end else if (ctrl.clr_wr) begin
				ptr_q      <= ptr_q + CW'(1);
				rd_valid_q <= 1'b0;
			end else begin
				rd_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			kind_q <= item.kind;
			idx_q  <= item.cluster_index;
			val_q  <= item.entry_value;
			prev_q <= item.link_from;
			cur_q  <= item.cluster_index;
		end else if (ctrl.walk_clr) begin
			cur_q <= rdata_q;
		end
		if (ctrl.scan_step) begin
			rd_addr_q <= ptr_q[AW-1:0];
		end
		if (ctrl.fin) begin
			result_q.result_value <= res_val;
			result_q.freed_count  <= freed_q;
			result_q.status       <= ctrl.fin_status;
		end
	end

	always_comb begin
		case (ctrl.fin_val)
			VAL_RDATA: res_val = rdata_q;
			VAL_FOUND: res_val = 16'(rd_addr_q);
			default:   res_val = LINK_FREE;
		endcase
	end

	always_comb begin
		stat.kind      = kind_q;
		stat.clr_last  = (ptr_q == CW'(TABLE_DEPTH - 1));
		stat.idx_ok    = ({1'b0, idx_q} < count);
		stat.prev_nz   = (prev_q != LINK_FREE);
		stat.prev_bad  = (prev_q != LINK_FREE) && !({1'b0, prev_q} < count);
		stat.found     = rd_valid_q && (rdata_q == LINK_FREE);
		stat.scan_more = (CNT_W'(ptr_q) < count);
		stat.cur_data  = (cur_q >= FIRST_DATA) && (cur_q <= LINK_LAST_DATA);
		stat.cur_ok    = ({1'b0, cur_q} < count);
		stat.limit     = (CNT_W'(freed_q) >= count);
	end

	assign result = result_q;

endmodule

`default_nettype wire

// ===== rtl/core/fcce_controller.sv =====
// Controller state machine of the FAT16 cluster chain engine.
`default_nettype none

module fcce_controller (
	input  wire                  clk,
	input  wire                  arst_n,
	input  wire                  start,
	output logic                 busy,
	output logic                 done,
	input  fcce_pkg::fcce_stat_t stat,
	output fcce_pkg::fcce_ctrl_t ctrl
);
	import fcce_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_DECODE,
		S_READ,
		S_SCAN,
		S_MARK,
		S_LINK,
		S_WALK,
		S_WALK_WB
	} state_t;

	state_t state_q;
	state_t state_d;
	logic   busy_q;
	logic   done_q;

	always_comb begin
		ctrl    = '0;
		state_d = state_q;
		case (state_q)
			S_CLEAR: begin
				ctrl.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					ctrl.load = 1'b1;
					state_d   = S_DECODE;
				end
			end
			S_DECODE: begin
				case (stat.kind)
					KIND_WRITE: begin
						ctrl.wr_idx     = stat.idx_ok;
						ctrl.fin        = 1'b1;
						ctrl.fin_status = stat.idx_ok ? ST_OK : ST_RANGE;
						state_d         = S_IDLE;
					end
					KIND_READ: begin
						if (stat.idx_ok) begin
							ctrl.rd_idx = 1'b1;
							state_d     = S_READ;
						end else begin
							ctrl.fin        = 1'b1;
							ctrl.fin_status = ST_RANGE;
							state_d         = S_IDLE;
						end
					end
					KIND_ALLOC: begin
						if (stat.prev_bad) begin
							ctrl.fin        = 1'b1;
							ctrl.fin_status = ST_RANGE;
							state_d         = S_IDLE;
						end else begin
							ctrl.scan_start = 1'b1;
							state_d         = S_SCAN;
						end
					end
					default: begin
						state_d = S_WALK;
					end
				endcase
			end
			S_READ: begin
				ctrl.fin     = 1'b1;
				ctrl.fin_val = VAL_RDATA;
				state_d      = S_IDLE;
			end
			S_SCAN: begin
				if (stat.found) begin
					state_d = S_MARK;
				end else if (stat.scan_more) begin
					ctrl.scan_step = 1'b1;
				end else begin
					ctrl.fin        = 1'b1;
					ctrl.fin_status = ST_FULL;
					state_d         = S_IDLE;
				end
			end
			S_MARK: begin
				ctrl.mark = 1'b1;
				if (stat.prev_nz) begin
					state_d = S_LINK;
				end else begin
					ctrl.fin     = 1'b1;
					ctrl.fin_val = VAL_FOUND;
					state_d      = S_IDLE;
				end
			end
			S_LINK: begin
				ctrl.link    = 1'b1;
				ctrl.fin     = 1'b1;
				ctrl.fin_val = VAL_FOUND;
				state_d      = S_IDLE;
			end
			S_WALK: begin
				if (!stat.cur_data) begin
					ctrl.fin = 1'b1;
					state_d  = S_IDLE;
				end else if (!stat.cur_ok) begin
					ctrl.fin        = 1'b1;
					ctrl.fin_status = ST_RANGE;
					state_d         = S_IDLE;
				end else if (stat.limit) begin
					ctrl.fin        = 1'b1;
					ctrl.fin_status = ST_LIMIT;
					state_d         = S_IDLE;
				end else begin
					ctrl.walk_rd = 1'b1;
					state_d      = S_WALK_WB;
				end
			end
			S_WALK_WB: begin
				ctrl.walk_clr = 1'b1;
				state_d       = S_WALK;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy_q  <= 1'b1;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			busy_q  <= (state_d != S_IDLE);
			done_q  <= ctrl.fin;
		end
	end

	assign busy = busy_q;
	assign done = done_q;

	// A result beat always ends an item, so the engine is free again while it is shown.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q && state_q == S_IDLE)
		else $error("result beat while the engine is still busy");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q)
		else $error("two result beats in consecutive cycles");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && $past(state_q) != S_CLEAR)
		else $error("result beat without an item in progress");

	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLEAR |-> busy_q && !ctrl.load)
		else $error("item taken during the table initialisation");

endmodule

`default_nettype wire

// ===== rtl/core/fat_cluster_chain_engine.sv =====
// Top level of the FAT16 cluster chain engine.
// After reset the whole table is initialised while busy is high.
// Write and read check the index against the active count; allocate marks the first free
// entry end of chain and links a previous cluster to it; free clears a chain entry by entry.
// The allocate scan reads one entry per cycle; the chain walk reads each link, then clears it.
// One item at a time; the result beat is shown for one cycle and cannot be stalled.
`default_nettype none

module fat_cluster_chain_engine #(
	parameter int unsigned TABLE_DEPTH = 4096
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          start,
	output logic                         busy,
	input  fcce_pkg::fcce_item_t         item,
	output logic                         done,
	output fcce_pkg::fcce_result_t       result,
	input  wire                          cfg_valid,
	output logic                         cfg_ready,
	input  wire [fcce_pkg::CFG_W-1:0]    cfg_data
);
	import fcce_pkg::*;

	fcce_ctrl_t ctrl;
	fcce_stat_t stat;

	fcce_controller u_controller (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	fcce_datapath #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data),
		.ctrl      (ctrl),
		.stat      (stat),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the FAT16 cluster chain engine with its own table predictor.
`timescale 1ns / 100ps

module tb;
	import fcce_pkg::*;

	localparam int unsigned TABLE_DEPTH = 4096;
	localparam int unsigned TAW         = $clog2(TABLE_DEPTH);
	localparam int unsigned STALL_LIMIT = 40000;
	localparam int unsigned ITEM_GOAL   = 1350;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	fcce_item_t           item_r;
	logic                 done;
	fcce_result_t         result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_W-1:0]     cfg_data;

	logic [15:0]          fat_links [TABLE_DEPTH];
	logic [CFG_W-1:0]     active_cfg;
	fcce_result_t         awaited_results [$];
	logic [15:0]          chain_heads [$];

	int unsigned items_sent;
	int unsigned results_seen;
	int unsigned mismatch_count;
	int unsigned cfg_writes;
	int unsigned stall_cycles;
	int unsigned burst_left;
	int unsigned kind_tally [4];

	fat_cluster_chain_engine #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item_r),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int unsigned live_entries();
		return (32'(active_cfg) < TABLE_DEPTH) ? 32'(active_cfg) : TABLE_DEPTH;
	endfunction

	function automatic fcce_result_t apply_fat_item(input fcce_item_t it);
		fcce_result_t r;
		int unsigned  cnt;
		int unsigned  idx;
		int unsigned  prev;
		int unsigned  cur;
		int unsigned  nxt;
		int unsigned  e;
		int unsigned  found;
		int unsigned  freed;
		bit           stop;
		cnt = live_entries();
		idx = 32'(it.cluster_index);
		prev = 32'(it.link_from);
		r = '0;
		r.status = ST_OK;
		freed = 0;
		case (it.kind)
			KIND_WRITE: begin
				if (idx < cnt)
					fat_links[idx[TAW-1:0]] = it.entry_value;
				else
					r.status = ST_RANGE;
			end
			KIND_READ: begin
				if (idx < cnt)
					r.result_value = fat_links[idx[TAW-1:0]];
				else
					r.status = ST_RANGE;
			end
			KIND_ALLOC: begin
				if (prev != 0 && prev >= cnt) begin
					r.status = ST_RANGE;
				end else begin
					found = 0;
					for (e = 2; e < cnt; e++)
						if (found == 0 && fat_links[e[TAW-1:0]] == LINK_FREE)
							found = e;
					if (found == 0) begin
						r.status = ST_FULL;
					end else begin
						fat_links[found[TAW-1:0]] = LINK_EOC;
						if (prev != 0)
							fat_links[prev[TAW-1:0]] = 16'(found);
						r.result_value = 16'(found);
					end
				end
			end
			default: begin
				cur = idx;
				stop = 1'b0;
				while (!stop && cur >= 2 && cur <= LINK_LAST_DATA) begin
					if (cur >= cnt) begin
						r.status = ST_RANGE;
						stop = 1'b1;
					end else if (freed >= cnt) begin
						r.status = ST_LIMIT;
						stop = 1'b1;
					end else begin
						nxt = 32'(fat_links[cur[TAW-1:0]]);
						fat_links[cur[TAW-1:0]] = LINK_FREE;
						freed++;
						cur = nxt;
					end
				end
			end
		endcase
		r.freed_count = freed[CFG_W-1:0];
		return r;
	endfunction

	function automatic fcce_item_t mk(input kind_t k, input logic [15:0] idx,
			input logic [15:0] val, input logic [15:0] prev);
		fcce_item_t it;
		it.kind = k;
		it.cluster_index = idx;
		it.entry_value = val;
		it.link_from = prev;
		return it;
	endfunction

	function automatic logic [15:0] pick_index(input int unsigned cnt);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 7)
			return 16'($urandom_range(0, cnt + 1));
		else if (r == 7)
			return 16'hFFFF - 16'($urandom_range(0, 8));
		else
			return 16'($urandom);
	endfunction

	function automatic logic [15:0] pick_value(input int unsigned cnt);
		int unsigned r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return 16'($urandom_range(0, cnt + 1));
		else if (r == 5)
			return LINK_EOC;
		else if (r == 6)
			return LINK_FREE;
		else if (r == 7)
			return LINK_LAST_DATA + 16'($urandom_range(0, 1));
		else
			return 16'($urandom);
	endfunction

	task automatic send_item(input fcce_item_t it, output fcce_result_t predicted);
		int unsigned gap;
		if (burst_left > 0) begin
			gap = 0;
			burst_left--;
		end else begin
			if ($urandom_range(0, 15) == 0)
				burst_left = $urandom_range(5, 30);
			gap = $urandom_range(0, 12);
		end
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		item_r <= it;
		do @(posedge clk); while (busy);
		predicted = apply_fat_item(it);
		awaited_results.push_back(predicted);
		items_sent++;
		kind_tally[it.kind]++;
	endtask

	task automatic write_active(input logic [CFG_W-1:0] v);
		start <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		active_cfg = v;
		cfg_writes++;
	endtask

	task automatic test_formatted_table();
		fcce_result_t r;
		send_item(mk(KIND_READ, 16'd0, 16'd0, 16'd0), r);
		send_item(mk(KIND_READ, 16'd1, 16'hFFFF, 16'hFFFF), r);
		send_item(mk(KIND_READ, 16'd4096, 16'd0, 16'd0), r);
		send_item(mk(KIND_WRITE, 16'hFFFF, 16'hFFFF, 16'd0), r);
		send_item(mk(KIND_WRITE, 16'd4095, 16'hFFFF, 16'd0), r);
		send_item(mk(KIND_READ, 16'd4095, 16'd0, 16'd0), r);
		send_item(mk(KIND_WRITE, 16'd4095, 16'd0, 16'd0), r);
	endtask

	task automatic test_alloc_and_free();
		fcce_result_t r;
		send_item(mk(KIND_ALLOC, 16'd0, 16'd0, 16'd0), r);
		send_item(mk(KIND_ALLOC, 16'd0, 16'd0, 16'd2), r);
		send_item(mk(KIND_ALLOC, 16'd0, 16'd0, 16'hFFFF), r);
		// The next free cluster is also the previous one, so it links to itself.
		send_item(mk(KIND_ALLOC, 16'd0, 16'd0, 16'd4), r);
		send_item(mk(KIND_FREE, 16'd2, 16'd0, 16'd0), r);
		send_item(mk(KIND_FREE, 16'd4, 16'd0, 16'd0), r);
		send_item(mk(KIND_FREE, 16'd0, 16'd0, 16'd0), r);
		send_item(mk(KIND_FREE, 16'd1, 16'd0, 16'd0), r);
		send_item(mk(KIND_FREE, LINK_MEDIA, 16'd0, 16'd0), r);
		send_item(mk(KIND_WRITE, 16'd5, 16'h1000, 16'd0), r);
		send_item(mk(KIND_FREE, 16'd5, 16'd0, 16'd0), r);
	endtask

	task automatic test_small_counts();
		fcce_result_t r;
		write_active(13'd0);
		send_item(mk(KIND_ALLOC, 16'd0, 16'd0, 16'd0), r);
		send_item(mk(KIND_READ, 16'd0, 16'd0, 16'd0), r);
		write_active(13'd2);
		send_item(mk(KIND_ALLOC, 16'd0, 16'd0, 16'd0), r);
		write_active(13'd3);
		send_item(mk(KIND_WRITE, 16'd2, 16'd0, 16'd0), r);
		send_item(mk(KIND_ALLOC, 16'd0, 16'd0, 16'd0), r);
		send_item(mk(KIND_ALLOC, 16'd0, 16'd0, 16'd0), r);
		send_item(mk(KIND_ALLOC, 16'd0, 16'd0, 16'd3), r);
		write_active(13'h1FFF);
		send_item(mk(KIND_READ, 16'd4095, 16'd0, 16'd0), r);
	endtask

	task automatic test_random_phases();
		int unsigned  plan [14];
		int unsigned  cnt;
		int unsigned  target;
		int unsigned  a;
		int unsigned  len;
		int unsigned  k;
		int unsigned  step;
		logic [15:0]  prev;
		logic [15:0]  idx;
		fcce_result_t r;
		plan = '{8191, 3, 17, 4096, 5, 40, 0, 64, 1, 300, 2, 12, 4096, 4};
		foreach (plan[p]) begin
			write_active(13'(plan[p]));
			cnt = live_entries();
			target = items_sent + ((cnt < 3) ? 30 : 115);
			chain_heads.delete();
			while (items_sent < target) begin
				a = $urandom_range(0, 99);
				if (a < 35) begin
					len = $urandom_range(1, 8);
					prev = ($urandom_range(0, 4) == 0) ? pick_index(cnt) : 16'd0;
					for (k = 0; k < len; k++) begin
						send_item(mk(KIND_ALLOC, pick_index(cnt), pick_value(cnt), prev), r);
						if (r.status != ST_OK) begin
							k = len;
						end else begin
							if (k == 0)
								chain_heads.push_back(r.result_value);
							prev = r.result_value;
						end
					end
					if (chain_heads.size() > 32)
						void'(chain_heads.pop_front());
				end else if (a < 55) begin
					if (chain_heads.size() > 0 && $urandom_range(0, 4) != 0) begin
						k = $urandom_range(0, chain_heads.size() - 1);
						idx = chain_heads[k];
						chain_heads.delete(k);
					end else begin
						idx = pick_index(cnt);
					end
					send_item(mk(KIND_FREE, idx, pick_value(cnt), pick_index(cnt)), r);
				end else if (a < 70) begin
					if (chain_heads.size() > 0 && $urandom_range(0, 3) != 0)
						idx = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
					else
						idx = pick_index(cnt);
					for (step = 0; step < 10; step++) begin
						send_item(mk(KIND_READ, idx, pick_value(cnt), pick_index(cnt)), r);
						if (r.status == ST_OK && r.result_value >= FIRST_DATA &&
								r.result_value <= LINK_LAST_DATA)
							idx = r.result_value;
						else
							step = 10;
					end
				end else if (a < 82) begin
					send_item(mk(KIND_WRITE, pick_index(cnt), pick_value(cnt),
						pick_index(cnt)), r);
				end else begin
					send_item(mk(kind_t'($urandom_range(0, 3)), 16'($urandom),
						16'($urandom), 16'($urandom)), r);
				end
			end
		end
	endtask

	always @(posedge clk) begin
		fcce_result_t want;
		if (arst_n && done) begin
			results_seen++;
			if (awaited_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("Unexpected result beat: value %h freed %0d status %0d",
						result.result_value, result.freed_count, result.status);
			end else begin
				want = awaited_results.pop_front();
				if (result.result_value !== want.result_value ||
						result.freed_count !== want.freed_count ||
						result.status !== want.status) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("Result mismatch: expected %h/%0d/%0d, got %h/%0d/%0d",
							want.result_value, want.freed_count, want.status,
							result.result_value, result.freed_count, result.status);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || done || (cfg_valid && cfg_ready)) begin
			stall_cycles <= 0;
		end else begin
			stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("Watchdog expired with %0d results outstanding",
					awaited_results.size());
				$display("SCOREBOARD MISMATCH");
				$finish;
			end
		end
	end

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		item_r <= '0;
		cfg_valid <= 1'b0;
		cfg_data <= '0;
		foreach (fat_links[i])
			fat_links[i] = LINK_FREE;
		fat_links[0] = LINK_MEDIA;
		fat_links[1] = LINK_EOC;
		active_cfg = ACTIVE_RESET;
		items_sent = 0;
		results_seen = 0;
		mismatch_count = 0;
		cfg_writes = 0;
		burst_left = 0;
		foreach (kind_tally[i])
			kind_tally[i] = 0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		test_formatted_table();
		test_alloc_and_free();
		test_small_counts();
		test_random_phases();

		start <= 1'b0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (64) @(posedge clk);

		$display("Run covered %0d items (%0d write, %0d read, %0d allocate, %0d free), %0d results.",
			items_sent, kind_tally[KIND_WRITE], kind_tally[KIND_READ],
			kind_tally[KIND_ALLOC], kind_tally[KIND_FREE], results_seen);
		$display("Table size was written %0d times, from empty up to beyond the depth.",
			cfg_writes);
		if (mismatch_count == 0 && awaited_results.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/core/fcce_pkg.sv
rtl/core/fcce_datapath.sv
rtl/core/fcce_controller.sv
rtl/core/fat_cluster_chain_engine.sv
tb/sv/tb.sv
